@@ sv/akmpd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the anti-kt minimum pair distance unit.
// No dependencies.
package akmpd_pkg;

   localparam int GROUP_SIZE = 8;
   localparam int LANE_W     = $clog2(GROUP_SIZE);
   localparam int ROT_W      = $clog2(GROUP_SIZE / 2 + 1);

   localparam int PT_W    = 16;
   localparam int ETA_W   = 16;
   localparam int PHI_W   = 15;
   localparam int STORE_W = 16;
   localparam int CSR_W   = 16;
   localparam int DIST_W  = 32;
   localparam int OUT_LANE_W = 3;

   localparam int DIFF_W  = STORE_W + 1;
   localparam int SQ_W    = 2 * DIFF_W;
   localparam int DR2_W   = SQ_W + 1;
   localparam int P2_W    = 2 * PT_W;
   localparam int PROD_W  = DR2_W + CSR_W;
   localparam int DEN_SHIFT = 12;
   localparam int NUM_W   = PROD_W - DEN_SHIFT;
   localparam int DIV_STEPS = DIST_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic signed [DIFF_W:0] PI_FX    = 18'sd12868;
   localparam logic signed [DIFF_W:0] TWOPI_FX = 18'sd25736;

   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-3:0] CSR_INV_R0_SQ = '0;
   localparam logic [CSR_W-1:0] INV_R0_SQ_RESET = 16'd25600;

   typedef enum logic [8:0] {
      ST_COLLECT = 9'b000000001,
      ST_READ    = 9'b000000010,
      ST_DIFF    = 9'b000000100,
      ST_SQUARE  = 9'b000001000,
      ST_SUM     = 9'b000010000,
      ST_SCALE   = 9'b000100000,
      ST_DIVIDE  = 9'b001000000,
      ST_UPDATE  = 9'b010000000,
      ST_FINISH  = 9'b100000000
   } state_type;

   typedef struct packed {
      logic              wr_en;
      logic [LANE_W-1:0] wr_lane;
      logic              rd_en;
      logic [LANE_W-1:0] lane_a;
      logic [LANE_W-1:0] lane_b;
      logic              diff_en;
      logic              square_en;
      logic              sum_en;
      logic              scale_en;
      logic              div_en;
      logic              update_en;
      logic              update_first;
      logic              out_load;
   } cmd_type;

   typedef struct packed {
      logic evaluating;
      logic finishing;
   } status_type;

endpackage

@@ sv/akmpd_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for particle input and pair result beats.
// Depends on akmpd_pkg.
interface akmpd_req_if import akmpd_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [PT_W-1:0]         pt;
   logic signed [ETA_W-1:0] eta;
   logic signed [PHI_W-1:0] phi;
   modport source (output valid, output pt, output eta, output phi, input ready);
   modport sink   (input valid, input pt, input eta, input phi, output ready);
endinterface

interface akmpd_rsp_if import akmpd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [OUT_LANE_W-1:0] lane_a;
   logic [OUT_LANE_W-1:0] lane_b;
   logic [DIST_W-1:0]     min_distance;
   modport source (output valid, output lane_a, output lane_b, output min_distance,
                   input ready);
   modport sink   (input valid, input lane_a, input lane_b, input min_distance,
                   output ready);
endinterface

@@ sv/akmpd_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer: particle collection, pair walk, divider step count, result beat.
// Depends on akmpd_pkg.
module akmpd_ctrl import akmpd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output cmd_type    cmd,
   output status_type status
);

   state_type              state_ff, state_in;
   logic [LANE_W-1:0]      fill_ff, fill_in;
   logic [LANE_W-1:0]      lane_ff, lane_in;
   logic [ROT_W-1:0]       rot_ff, rot_in;
   logic [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [LANE_W:0]        lane_ext;
   logic [LANE_W:0]        rot_ext;
   logic [LANE_W:0]        partner;

   always_comb begin
      lane_ext = {1'b0, lane_ff};
      rot_ext  = (LANE_W + 1)'(rot_ff);
      if (lane_ext >= rot_ext) begin
         partner = lane_ext - rot_ext;
      end else begin
         partner = lane_ext + (LANE_W + 1)'(GROUP_SIZE) - rot_ext;
      end
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      lane_in      = lane_ff;
      rot_in       = rot_ff;
      div_cnt_in   = div_cnt_ff;
      cmd          = '0;
      cmd.wr_lane  = fill_ff;
      cmd.lane_a   = lane_ff;
      cmd.lane_b   = partner[LANE_W-1:0];
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_COLLECT: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.wr_en = 1'b1;
               if (fill_ff == LANE_W'(GROUP_SIZE - 1)) begin
                  fill_in  = '0;
                  lane_in  = '0;
                  rot_in   = ROT_W'(1);
                  state_in = ST_READ;
               end else begin
                  fill_in = fill_ff + 1'b1;
               end
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.diff_en = 1'b1;
            state_in    = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.square_en = 1'b1;
            state_in      = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale_en = 1'b1;
            div_cnt_in   = '0;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_en = 1'b1;
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update_en    = 1'b1;
            cmd.update_first = (rot_ff == ROT_W'(1)) && (lane_ff == '0);
            if (lane_ff == LANE_W'(GROUP_SIZE - 1)) begin
               lane_in = '0;
               if (rot_ff == ROT_W'(GROUP_SIZE / 2)) begin
                  state_in = ST_FINISH;
               end else begin
                  rot_in   = rot_ff + 1'b1;
                  state_in = ST_READ;
               end
            end else begin
               lane_in  = lane_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_COLLECT;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         fill_ff      <= '0;
         lane_ff      <= '0;
         rot_ff       <= ROT_W'(1);
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         lane_ff      <= lane_in;
         rot_ff       <= rot_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign status.evaluating  = (state_ff != ST_COLLECT);
   assign status.finishing   = (state_ff == ST_FINISH);

endmodule

@@ sv/akmpd_datapath.sv @@
`timescale 1ns / 1ps
// Particle stores, pair distance unit with restoring divider, best-pair tracker.
// Depends on akmpd_pkg; driven by akmpd_ctrl commands.
module akmpd_datapath import akmpd_pkg::*; (
   input  logic                    clock,
   input  cmd_type                 cmd,
   input  logic [CSR_W-1:0]        inv_r0_sq,
   input  logic [PT_W-1:0]         in_pt,
   input  logic signed [ETA_W-1:0] in_eta,
   input  logic signed [PHI_W-1:0] in_phi,
   output logic [OUT_LANE_W-1:0]   out_lane_a,
   output logic [OUT_LANE_W-1:0]   out_lane_b,
   output logic [DIST_W-1:0]       out_distance
);

   logic [PT_W-1:0]           pt_mem  [GROUP_SIZE];
   logic signed [STORE_W-1:0] eta_mem [GROUP_SIZE];
   logic signed [STORE_W-1:0] phi_mem [GROUP_SIZE];

   logic [PT_W-1:0]           pt_a_ff, pt_b_ff;
   logic signed [STORE_W-1:0] eta_a_ff, eta_b_ff, phi_a_ff, phi_b_ff;

   logic signed [DIFF_W-1:0]  deta_ff, deta_in;
   logic signed [DIFF_W-1:0]  dphi_ff, dphi_in;
   logic [PT_W-1:0]           pmax_ff, pmax_in;
   logic signed [DIFF_W:0]    dphi_raw;

   logic [SQ_W-1:0]           sq_eta_ff, sq_phi_ff;
   logic [P2_W-1:0]           p2_ff;
   logic signed [SQ_W-1:0]    sq_eta_s, sq_phi_s;
   logic [DR2_W-1:0]          dr2_ff;

   logic [PROD_W-1:0]         prod;
   logic [NUM_W-1:0]          num;
   logic [DIST_W-1:0]         rem_ff, rem_in;
   logic [DIST_W-1:0]         dq_ff, dq_in;
   logic                      sat_ff, sat_in;
   logic [DIST_W:0]           trial;
   logic [DIST_W-1:0]         pair_d;

   logic [DIST_W-1:0]         best_ff;
   logic [LANE_W-1:0]         best_a_ff, best_b_ff;
   logic [OUT_LANE_W-1:0]     out_a_ff, out_b_ff;
   logic [DIST_W-1:0]         out_d_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         pt_mem[cmd.wr_lane]  <= in_pt;
         eta_mem[cmd.wr_lane] <= STORE_W'(in_eta);
         phi_mem[cmd.wr_lane] <= STORE_W'(in_phi);
      end
      if (cmd.rd_en) begin
         pt_a_ff  <= pt_mem[cmd.lane_a];
         eta_a_ff <= eta_mem[cmd.lane_a];
         phi_a_ff <= phi_mem[cmd.lane_a];
         pt_b_ff  <= pt_mem[cmd.lane_b];
         eta_b_ff <= eta_mem[cmd.lane_b];
         phi_b_ff <= phi_mem[cmd.lane_b];
      end
   end

   // difference and phase wrap
   always_comb begin
      deta_in  = DIFF_W'(eta_a_ff) - DIFF_W'(eta_b_ff);
      dphi_raw = (DIFF_W + 1)'(phi_a_ff) - (DIFF_W + 1)'(phi_b_ff);
      if (dphi_raw > PI_FX) begin
         dphi_in = DIFF_W'(dphi_raw - TWOPI_FX);
      end else if (dphi_raw < -PI_FX) begin
         dphi_in = DIFF_W'(dphi_raw + TWOPI_FX);
      end else begin
         dphi_in = DIFF_W'(dphi_raw);
      end
      pmax_in = (pt_a_ff > pt_b_ff) ? pt_a_ff : pt_b_ff;
   end

   assign sq_eta_s = deta_ff * deta_ff;
   assign sq_phi_s = dphi_ff * dphi_ff;

   // scale by 1/R0^2 and drop the 4096 of the denominator
   assign prod = PROD_W'(dr2_ff) * PROD_W'(inv_r0_sq);
   assign num  = prod[PROD_W-1:DEN_SHIFT];

   always_comb begin
      rem_in = rem_ff;
      dq_in  = dq_ff;
      sat_in = sat_ff;
      trial  = {rem_ff, dq_ff[DIST_W-1]};
      if (cmd.scale_en) begin
         rem_in = DIST_W'(num[NUM_W-1:DIST_W]);
         dq_in  = num[DIST_W-1:0];
         sat_in = (p2_ff == '0) || (DIST_W'(num[NUM_W-1:DIST_W]) >= p2_ff);
      end else if (cmd.div_en) begin
         if (trial >= {1'b0, p2_ff}) begin
            rem_in = DIST_W'(trial - {1'b0, p2_ff});
            dq_in  = {dq_ff[DIST_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIST_W-1:0];
            dq_in  = {dq_ff[DIST_W-2:0], 1'b0};
         end
      end
   end

   assign pair_d = sat_ff ? '1 : dq_ff;

   always_ff @(posedge clock) begin
      if (cmd.diff_en) begin
         deta_ff <= deta_in;
         dphi_ff <= dphi_in;
         pmax_ff <= pmax_in;
      end
      if (cmd.square_en) begin
         sq_eta_ff <= SQ_W'(sq_eta_s);
         sq_phi_ff <= SQ_W'(sq_phi_s);
         p2_ff     <= P2_W'(pmax_ff) * P2_W'(pmax_ff);
      end
      if (cmd.sum_en) begin
         dr2_ff <= DR2_W'(sq_eta_ff) + DR2_W'(sq_phi_ff);
      end
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
      sat_ff <= sat_in;
      if (cmd.update_en && (cmd.update_first || pair_d <= best_ff)) begin
         best_ff   <= pair_d;
         best_a_ff <= cmd.lane_a;
         best_b_ff <= cmd.lane_b;
      end
      if (cmd.out_load) begin
         out_a_ff <= OUT_LANE_W'(best_a_ff);
         out_b_ff <= OUT_LANE_W'(best_b_ff);
         out_d_ff <= best_ff;
      end
   end

   assign out_lane_a   = out_a_ff;
   assign out_lane_b   = out_b_ff;
   assign out_distance = out_d_ff;

endmodule

@@ sv/antikt_min_pair_distance_unit.sv @@
`timescale 1ns / 1ps
// Top level of the anti-kt minimum pair distance unit: CSR, sequencer, datapath.
// Depends on akmpd_pkg, akmpd_if, akmpd_ctrl and akmpd_datapath.
//
//  channel   direction  beat contents
//  req_ch    in         pt, eta, phi of one particle
//  rsp_ch    out        lane_a, lane_b, min_distance of the closest pair
//  apb       in         inv_r0_sq at address 0
//
// Particle beats are taken while collecting; the 8th starts the evaluation of 32
// pairs on one shared distance unit (5 pipeline steps, 32 divider steps of the
// 1-bit/cycle divider, 1 update), then a finish step that waits until the
// output register is free.
// Reset clears the sequencer and sets inv_r0_sq to 25600. A stalled result
// waits in the output register while the next group is collected.
module antikt_min_pair_distance_unit import akmpd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   akmpd_req_if.sink             req_ch,
   akmpd_rsp_if.source           rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   logic [CSR_W-1:0] inv_r0_sq_ff, inv_r0_sq_in;
   cmd_type          cmd;
   status_type       status;
   logic             csr_hit;

   assign pready  = 1'b1;
   assign csr_hit = (paddr[CSR_ADDR_W-1:2] == CSR_INV_R0_SQ);

   always_comb begin
      inv_r0_sq_in = inv_r0_sq_ff;
      if (psel && penable && pwrite && csr_hit) begin
         inv_r0_sq_in = pwdata[CSR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_r0_sq_ff <= INV_R0_SQ_RESET;
      end else begin
         inv_r0_sq_ff <= inv_r0_sq_in;
      end
   end

   assign prdata = csr_hit ? {{(32 - CSR_W){1'b0}}, inv_r0_sq_ff} : 32'd0;

   akmpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   akmpd_datapath u_datapath (
      .clock        (clock),
      .cmd          (cmd),
      .inv_r0_sq    (inv_r0_sq_ff),
      .in_pt        (req_ch.pt),
      .in_eta       (req_ch.eta),
      .in_phi       (req_ch.phi),
      .out_lane_a   (rsp_ch.lane_a),
      .out_lane_b   (rsp_ch.lane_b),
      .out_distance (rsp_ch.min_distance)
   );

   a_busy_no_req: assert property (@(posedge clock) disable iff (reset)
      status.evaluating |-> !req_ch.ready)
      else $error("particle beat accepted during evaluation");

   a_rsp_after_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(status.finishing))
      else $error("result beat raised outside finish");

   a_distinct_lanes: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.lane_a != rsp_ch.lane_b))
      else $error("result pairs a lane with itself");

endmodule
